// File: design/phasor_polynomial_sine_oscillator_defines.svh
// Assertion macros shared by the oscillator RTL.
`ifndef PHASOR_POLYNOMIAL_SINE_OSCILLATOR_DEFINES_SVH
`define PHASOR_POLYNOMIAL_SINE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPSO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oscillator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PPSO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oscillator check failed");

`endif

// File: design/ppso_pkg.sv
`default_nettype none

package ppso_pkg;

    localparam int PHASE_BITS = 24;
    localparam int SINE_BITS  = 16;
    localparam int QFRAC      = 22;
    localparam int Y_BITS     = 32;
    localparam int PROD_BITS  = Y_BITS + QFRAC + 1;
    localparam int OUT_SHIFT  = 24 - SINE_BITS;
    localparam int ROUND_ADD  = (OUT_SHIFT >= 2) ? (1 << (OUT_SHIFT - 1)) : 0;
    localparam int SAT_HI     = (1 << (SINE_BITS - 1)) - 1;
    localparam int SAT_LO     = -(1 << (SINE_BITS - 1));
    localparam int STEP_BITS  = 4;
    localparam int COEF_BITS  = 3;

    typedef logic [STEP_BITS-1:0] step_t;
    typedef logic [COEF_BITS-1:0] coef_idx_t;

    localparam step_t STEP_ACCEPT = step_t'(0);
    localparam step_t STEP_FINAL  = step_t'(7);
    localparam step_t STEP_EMIT   = step_t'(8);

    typedef enum logic [1:0] {
        OP_ACCEPT,
        OP_MAC,
        OP_MUL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t       op;
        coef_idx_t coef_idx;
        logic      coef_sub;
        step_t     next_step;
    } ctrl_t;

    // Q10.22 Horner coefficients, c7 first.
    function automatic logic signed [Y_BITS-1:0] coef(input coef_idx_t idx);
        logic signed [Y_BITS-1:0] c;
        case (idx)
            3'd0:    c = Y_BITS'(279224787);
            3'd1:    c = Y_BITS'(977286753);
            3'd2:    c = Y_BITS'(1156598164);
            3'd3:    c = Y_BITS'(448278528);
            3'd4:    c = Y_BITS'(657843);
            3'd5:    c = Y_BITS'(41351613);
            3'd6:    c = Y_BITS'(30436100);
            default: c = '0;
        endcase
        return c;
    endfunction

    // Microprogram: load c7 on accept, six multiply-accumulates, final multiply, emit.
    function automatic ctrl_t program_word(input step_t step);
        ctrl_t w;
        case (step)
            4'd0:    w = '{OP_ACCEPT, 3'd0, 1'b0, step_t'(1)};
            4'd1:    w = '{OP_MAC,    3'd1, 1'b1, step_t'(2)};
            4'd2:    w = '{OP_MAC,    3'd2, 1'b0, step_t'(3)};
            4'd3:    w = '{OP_MAC,    3'd3, 1'b1, step_t'(4)};
            4'd4:    w = '{OP_MAC,    3'd4, 1'b0, step_t'(5)};
            4'd5:    w = '{OP_MAC,    3'd5, 1'b1, step_t'(6)};
            4'd6:    w = '{OP_MAC,    3'd6, 1'b0, STEP_FINAL};
            4'd7:    w = '{OP_MUL,    3'd0, 1'b0, STEP_EMIT};
            4'd8:    w = '{OP_EMIT,   3'd0, 1'b0, STEP_ACCEPT};
            default: w = '{OP_EMIT,   3'd0, 1'b0, STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/phasor_polynomial_sine_oscillator.sv
// Channel   Signals                                        Dir  Transaction
// tick      tick_valid/tick_ready, phase_increment         in   one per sample
// result    result_valid/result_ready, saw_phase, sine_value  out  one per tick
// config    cfg_write_en, cfg_write_data (phase offset)    in   single-cycle write
//
// A tick runs through one accept step, seven steps through the shared
// 32x23 multiplier and one step writing the output register.
// The output register lets the next tick be accepted while a result waits;
// the emit step holds until that register is free.
// rst_n clears phase, offset, sequencer step and result valid; no clearing pass.
`default_nettype none
`include "phasor_polynomial_sine_oscillator_defines.svh"

module phasor_polynomial_sine_oscillator (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write_en,
    input  wire logic [ppso_pkg::PHASE_BITS-1:0]        cfg_write_data,
    input  wire logic                                   tick_valid,
    output logic                                        tick_ready,
    input  wire logic [ppso_pkg::PHASE_BITS-1:0]        phase_increment,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output logic [ppso_pkg::PHASE_BITS-1:0]             saw_phase,
    output logic signed [ppso_pkg::SINE_BITS-1:0]       sine_value
);

    logic [ppso_pkg::PHASE_BITS-1:0]            phase_acc_reg, phase_acc_next;
    logic [ppso_pkg::PHASE_BITS-1:0]            offset_reg;
    ppso_pkg::step_t                            step_reg, step_next;
    logic                                       result_valid_reg, result_valid_next;
    logic [ppso_pkg::QFRAC-1:0]                 x_reg, x_next;
    logic [ppso_pkg::PHASE_BITS-1:0]            saw_reg, saw_next;
    logic signed [ppso_pkg::Y_BITS-1:0]         y_reg, y_next;
    logic [ppso_pkg::PHASE_BITS-1:0]            saw_phase_reg, saw_phase_next;
    logic signed [ppso_pkg::SINE_BITS-1:0]      sine_value_reg, sine_value_next;

    ppso_pkg::ctrl_t                            ctrl;
    logic                                       accept;
    logic                                       out_free;
    logic                                       go;
    logic                                       emit;
    logic [ppso_pkg::PHASE_BITS-1:0]            saw;
    logic [ppso_pkg::PHASE_BITS+ppso_pkg::QFRAC-1:0] saw_wide;
    logic signed [ppso_pkg::PROD_BITS-1:0]      prod;
    logic signed [ppso_pkg::Y_BITS-1:0]         prod_q;
    logic signed [ppso_pkg::Y_BITS-1:0]         coef_val;
    logic signed [ppso_pkg::Y_BITS+1:0]         y_round;
    logic signed [ppso_pkg::Y_BITS+1:0]         v;
    logic signed [ppso_pkg::SINE_BITS-1:0]      sine_sat;

    assign ctrl       = ppso_pkg::program_word(step_reg);
    assign tick_ready = (ctrl.op == ppso_pkg::OP_ACCEPT);
    assign accept     = tick_valid && tick_ready;
    assign out_free   = !result_valid_reg || result_ready;
    assign emit       = (ctrl.op == ppso_pkg::OP_EMIT) && out_free;

    assign saw      = phase_acc_reg + offset_reg;
    assign saw_wide = {saw, {ppso_pkg::QFRAC{1'b0}}};

    assign prod     = ppso_pkg::PROD_BITS'(y_reg)
                      * ppso_pkg::PROD_BITS'($signed({1'b0, x_reg}));
    assign prod_q   = prod[ppso_pkg::QFRAC+ppso_pkg::Y_BITS-1:ppso_pkg::QFRAC];
    assign coef_val = ppso_pkg::coef(ctrl.coef_idx);

    // Q22 -> output format, round half up, then saturate
    assign y_round = $signed({y_reg[ppso_pkg::Y_BITS-1], y_reg, 1'b0})
                     + $signed((ppso_pkg::Y_BITS+2)'(ppso_pkg::ROUND_ADD));
    assign v       = y_round >>> ppso_pkg::OUT_SHIFT;

    always_comb
    begin
        if (v > $signed((ppso_pkg::Y_BITS+2)'(ppso_pkg::SAT_HI)))
        begin
            sine_sat = ppso_pkg::SINE_BITS'(ppso_pkg::SAT_HI);
        end
        else if (v < $signed((ppso_pkg::Y_BITS+2)'(ppso_pkg::SAT_LO)))
        begin
            sine_sat = ppso_pkg::SINE_BITS'(ppso_pkg::SAT_LO);
        end
        else
        begin
            sine_sat = v[ppso_pkg::SINE_BITS-1:0];
        end
    end

    always_comb
    begin
        go              = 1'b0;
        y_next          = y_reg;
        x_next          = x_reg;
        saw_next        = saw_reg;
        phase_acc_next  = phase_acc_reg;
        saw_phase_next  = saw_phase_reg;
        sine_value_next = sine_value_reg;
        case (ctrl.op)
            ppso_pkg::OP_ACCEPT:
            begin
                go = tick_valid;
                if (accept)
                begin
                    x_next         = saw_wide[ppso_pkg::PHASE_BITS+ppso_pkg::QFRAC-1 -:
                                              ppso_pkg::QFRAC];
                    saw_next       = saw;
                    y_next         = coef_val;
                    phase_acc_next = phase_acc_reg + phase_increment;
                end
            end
            ppso_pkg::OP_MAC:
            begin
                go     = 1'b1;
                y_next = ctrl.coef_sub ? (prod_q - coef_val) : (prod_q + coef_val);
            end
            ppso_pkg::OP_MUL:
            begin
                go     = 1'b1;
                y_next = prod_q;
            end
            ppso_pkg::OP_EMIT:
            begin
                go = out_free;
                if (out_free)
                begin
                    saw_phase_next  = saw_reg;
                    sine_value_next = sine_sat;
                end
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
        step_next = go ? ctrl.next_step : step_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            offset_reg       <= '0;
            step_reg         <= ppso_pkg::STEP_ACCEPT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_acc_reg    <= phase_acc_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
            begin
                offset_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        saw_reg        <= saw_next;
        y_reg          <= y_next;
        saw_phase_reg  <= saw_phase_next;
        sine_value_reg <= sine_value_next;
    end

    assign result_valid = result_valid_reg;
    assign saw_phase    = saw_phase_reg;
    assign sine_value   = sine_value_reg;

    `PPSO_ASSERT_NOW(a_step_in_program, 1'b1, step_reg <= ppso_pkg::STEP_EMIT)
    `PPSO_ASSERT_NEXT(a_accept_starts_mac, accept,
                      step_reg == ppso_pkg::step_t'(1))
    `PPSO_ASSERT_NEXT(a_phase_only_on_accept, !accept, $stable(phase_acc_reg))
    `PPSO_ASSERT_NEXT(a_emit_returns, emit,
                      result_valid && (step_reg == ppso_pkg::STEP_ACCEPT))

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int SHOWN_ERRORS = 10;

    typedef logic [ppso_pkg::PHASE_BITS-1:0]       phase_t;
    typedef logic signed [ppso_pkg::SINE_BITS-1:0] sine_t;

    typedef struct {
        phase_t saw;
        sine_t  sine;
    } tone_t;

    logic   clk             = 1'b0;
    logic   rst_n           = 1'b0;
    logic   cfg_write_en    = 1'b0;
    phase_t cfg_write_data  = '0;
    logic   tick_valid      = 1'b0;
    logic   tick_ready;
    phase_t phase_increment = '0;
    logic   result_valid;
    logic   result_ready    = 1'b0;
    phase_t saw_phase;
    sine_t  sine_value;

    phase_t tick_backlog[$];
    tone_t  tone_q[$];

    longint horner_coef[7];
    phase_t phase_model  = '0;
    phase_t offset_model = '0;
    bit     steady       = 1'b0;

    int mismatches   = 0;
    int strays       = 0;
    int ticks_sent   = 0;
    int tones_seen   = 0;
    int clipped      = 0;
    int offset_count = 0;
    int stall_cycles = 0;

    phasor_polynomial_sine_oscillator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .tick_valid     (tick_valid),
        .tick_ready     (tick_ready),
        .phase_increment(phase_increment),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .saw_phase      (saw_phase),
        .sine_value     (sine_value)
    );

    always #HALF_PERIOD clk = ~clk;

    // decimal coefficient in units of 1e-9 to Q22, rounded
    function automatic longint q22_of(input longint unsigned nano);
        return longint'((nano * 64'd4194304 + 64'd500000000) / 64'd1000000000);
    endfunction

    function automatic sine_t poly_sine(input phase_t saw);
        longint x;
        longint y;
        longint v;
        int     k;
        x = longint'(saw >> (ppso_pkg::PHASE_BITS - ppso_pkg::QFRAC));
        y = horner_coef[0];
        for (k = 1; k < 7; k++)
        begin
            y = (y * x) >>> ppso_pkg::QFRAC;
            if (k % 2 == 1)
                y = y - horner_coef[k];
            else
                y = y + horner_coef[k];
        end
        y = (y * x) >>> ppso_pkg::QFRAC;
        v = (y + 64) >>> 7;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return sine_t'(v);
    endfunction

    function automatic bit takes_break();
        return !steady && ($urandom_range(0, 99) < 26);
    endfunction

    function automatic phase_t pick_increment();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return phase_t'($urandom_range(0, 24'hFFFFFF));
        else if (r < 8)
            return phase_t'($urandom_range(0, 4095));
        else
            return phase_t'(24'hFFFFFF - $urandom_range(0, 4095));
    endfunction

    // tick driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
        end
        else if (!tick_valid || tick_ready)
        begin
            if (tick_backlog.size() != 0 && !takes_break())
            begin
                tick_valid      <= 1'b1;
                phase_increment <= tick_backlog.pop_front();
            end
            else
            begin
                tick_valid <= 1'b0;
            end
        end
    end

    // result check, then prediction of the tick accepted at this edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= !takes_break();
            if (result_valid && result_ready)
            begin
                tones_seen++;
                if (tone_q.size() == 0)
                begin
                    strays++;
                    if (strays + mismatches <= SHOWN_ERRORS)
                        $display("unexpected result saw=%h sine=%0d", saw_phase, sine_value);
                end
                else
                begin
                    if (saw_phase !== tone_q[0].saw || sine_value !== tone_q[0].sine)
                    begin
                        mismatches++;
                        if (strays + mismatches <= SHOWN_ERRORS)
                            $display("mismatch: expected saw=%h sine=%0d, got saw=%h sine=%0d",
                                     tone_q[0].saw, tone_q[0].sine, saw_phase, sine_value);
                    end
                    if (tone_q[0].sine == sine_t'(32767) || tone_q[0].sine == sine_t'(-32768))
                        clipped++;
                    void'(tone_q.pop_front());
                end
            end
            if (cfg_write_en)
                offset_model = cfg_write_data;
            if (tick_valid && tick_ready)
            begin
                tone_q.push_back('{phase_model + offset_model,
                                   poly_sine(phase_model + offset_model)});
                phase_model = phase_model + phase_increment;
                ticks_sent++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_valid && tick_ready) || (result_valid && result_ready) || cfg_write_en)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic drain();
        while (tick_backlog.size() != 0 || tick_valid || tone_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_offset(input phase_t value);
        drain();
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        offset_count++;
    endtask

    initial
    begin
        int     p;
        int     n;
        phase_t offsets[5];

        horner_coef[0] = q22_of(64'd66572376872);
        horner_coef[1] = q22_of(64'd233003319051);
        horner_coef[2] = q22_of(64'd275754490893);
        horner_coef[3] = q22_of(64'd106877929605);
        horner_coef[4] = q22_of(64'd156842001);
        horner_coef[5] = q22_of(64'd9858992921);
        horner_coef[6] = q22_of(64'd7256531812);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset offset: zero phase, quarter steps, wraps near one
        tick_backlog = '{24'h000000, 24'h400000, 24'h400000, 24'h400000, 24'h400000,
                         24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hAAAAAA,
                         24'h555555, 24'hFFFFFE};
        // probe around the positive and negative peaks for overshoot
        write_offset(24'h3FFF80);
        for (n = 0; n < 6; n++)
            tick_backlog.push_back(24'h000020);
        write_offset(24'hBFFF00);
        for (n = 0; n < 6; n++)
            tick_backlog.push_back(24'h000040);

        offsets[0] = 24'hFFFFFF;
        offsets[1] = 24'h000000;
        offsets[2] = 24'h400000;
        offsets[3] = phase_t'($urandom_range(0, 24'hFFFFFF));
        offsets[4] = phase_t'($urandom_range(0, 24'hFFFFFF));
        for (p = 0; p < 5; p++)
        begin
            write_offset(offsets[p]);
            steady = (p == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                tick_backlog.push_back(pick_increment());
        end

        drain();
        steady = 1'b0;
        $display("oscillator run: %0d ticks, %0d results, %0d offset settings",
                 ticks_sent, tones_seen, offset_count);
        $display("saturated samples: %0d, mismatches: %0d, unexpected results: %0d",
                 clipped, mismatches, strays);
        if (mismatches == 0 && strays == 0 && tone_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
